FILE: src/bcu_pkg.sv
`timescale 1ns / 1ps

package bcu_pkg;

    localparam int N_W    = 6;
    localparam int COEF_W = 31;
    localparam int PROD_W = COEF_W + N_W;
    localparam int CNT_W  = $clog2(PROD_W);

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [N_W-1:0]    divisor;
    } div_cmd_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: src/bcu_divider.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module bcu_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  bcu_pkg::div_cmd_t cmd,
    output bcu_pkg::div_rsp_t rsp
);

    logic [bcu_pkg::N_W-1:0]    rem_reg;
    logic [bcu_pkg::N_W-1:0]    rem_next;
    logic [bcu_pkg::PROD_W-1:0] quo_reg;
    logic [bcu_pkg::PROD_W-1:0] quo_next;
    logic [bcu_pkg::N_W-1:0]    dvs_reg;
    logic [bcu_pkg::CNT_W-1:0]  cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [bcu_pkg::N_W:0]      shifted;
    logic [bcu_pkg::N_W:0]      diff;
    logic                       fits;
    logic                       last;

    assign shifted = {rem_reg, quo_reg[bcu_pkg::PROD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign last    = cnt_reg == bcu_pkg::CNT_W'(bcu_pkg::PROD_W - 1);

    always_comb
    begin
        if (fits)
        begin
            rem_next = diff[bcu_pkg::N_W-1:0];
        end
        else
        begin
            rem_next = shifted[bcu_pkg::N_W-1:0];
        end
        quo_next = {quo_reg[bcu_pkg::PROD_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rem_reg <= '0;
            quo_reg <= cmd.dividend;
            dvs_reg <= cmd.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: src/binomial_coefficient_unit.sv
`timescale 1ns / 1ps

// Binomial coefficient n choose k, exact, by repeated multiply and exact divide
// over j = min(k, n-k) steps. Each step does the 31x6 multiply in S_MUL, starts
// the shared bit-serial divider in S_LAUNCH and waits for the quotient in S_WAIT;
// no new item is taken until the last step is done. Trivial cases (k of 0 or n,
// k above n, n above MAX_N) go straight to S_FINISH. Input stall stays high from
// acceptance until the result is placed in the output register; a waiting result
// does not block the next item. n above MAX_N gives zero with overflow set; k
// above n gives zero.
module binomial_coefficient_unit
#(
    parameter int MAX_N = 30
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [bcu_pkg::N_W-1:0]    n_total,
    input  logic [bcu_pkg::N_W-1:0]    k_chosen,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [bcu_pkg::COEF_W-1:0] coefficient,
    output logic                       overflow
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_LAUNCH = 3'd2;
    localparam logic [2:0] S_WAIT   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    localparam logic [bcu_pkg::N_W-1:0] MAX_N_V = bcu_pkg::N_W'(MAX_N);

    logic [2:0]                    state_reg;
    logic [bcu_pkg::N_W-1:0]       base_reg;
    logic [bcu_pkg::N_W-1:0]       steps_reg;
    logic [bcu_pkg::N_W-1:0]       i_reg;
    logic [bcu_pkg::COEF_W-1:0]    r_reg;
    logic                          ovf_reg;
    logic [bcu_pkg::PROD_W-1:0]    prod_reg;
    logic                          out_valid_reg;
    logic [bcu_pkg::COEF_W-1:0]    coefficient_reg;
    logic                          overflow_reg;

    logic                          in_accept;
    logic                          out_free;
    logic [bcu_pkg::N_W-1:0]       n_minus_k;
    logic [bcu_pkg::N_W-1:0]       k_min;
    logic [bcu_pkg::N_W-1:0]       factor;
    bcu_pkg::div_cmd_t             div_cmd;
    bcu_pkg::div_rsp_t             div_rsp;

    assign in_stall  = state_reg != S_IDLE;
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign n_minus_k = n_total - k_chosen;
    assign k_min     = (n_minus_k < k_chosen) ? n_minus_k : k_chosen;
    assign factor    = base_reg + i_reg;

    assign div_cmd.start    = state_reg == S_LAUNCH;
    assign div_cmd.dividend = prod_reg;
    assign div_cmd.divisor  = i_reg;

    bcu_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (n_total > MAX_N_V || k_chosen > n_total || k_min == '0)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_LAUNCH;
                end
                S_LAUNCH:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        if (i_reg == steps_reg)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ovf_reg   <= n_total > MAX_N_V;
            steps_reg <= k_min;
            base_reg  <= n_total - k_min;
            i_reg     <= bcu_pkg::N_W'(1);
            if (n_total > MAX_N_V || k_chosen > n_total)
            begin
                r_reg <= '0;
            end
            else
            begin
                r_reg <= bcu_pkg::COEF_W'(1);
            end
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= bcu_pkg::PROD_W'(r_reg) * bcu_pkg::PROD_W'(factor);
        end
        if (state_reg == S_WAIT && div_rsp.done)
        begin
            r_reg <= div_rsp.quotient[bcu_pkg::COEF_W-1:0];
            i_reg <= i_reg + 1'b1;
        end
        if (state_reg == S_FINISH && out_free)
        begin
            coefficient_reg <= r_reg;
            overflow_reg    <= ovf_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign coefficient = coefficient_reg;
    assign overflow    = overflow_reg;

endmodule
